// File: rtl/ptpcl_pkg.sv
// Shared constants and types for the PTP classifier and rate limiter.
package ptpcl_pkg;

  localparam int PORTS = 256;
  localparam int ROW_W = $clog2(PORTS);
  localparam int BUDGET_W = 9;
  localparam int CFG_ADDR_W = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PTP_ENABLED = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RX_BUDGET = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TX_BUDGET = 2'd2;

  localparam logic [BUDGET_W-1:0] RX_BUDGET_RESET = 9'd394;
  localparam logic [BUDGET_W-1:0] TX_BUDGET_RESET = 9'd404;

  localparam logic [15:0] KIND_VLAN = 16'h8100;
  localparam logic [15:0] KIND_PTP = 16'h88F7;
  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [15:0] KIND_IPV6 = 16'h86DD;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] PTP_EVENT_PORT = 16'd319;
  localparam logic [15:0] PTP_GENERAL_PORT = 16'd320;
  localparam logic [7:0] L3_PLAIN = 8'd14;
  localparam logic [7:0] L3_TAGGED = 8'd18;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result tdata layout
  localparam int OUT_TYPE_LSB = 0;
  localparam int OUT_DOMAIN_LSB = 4;
  localparam int OUT_SEQ_LSB = 12;
  localparam int OUT_TS_BIT = 28;
  localparam int OUT_OVER_BIT = 29;
  localparam int OUT_DIR_BIT = 30;
  localparam int OUT_DATA_W = 32;
  localparam int IN_DATA_W = 24;

  // frame summary held while the budget row is read
  typedef struct packed {
    logic [15:0] kind;
    logic [7:0] next_protocol;
    logic [15:0] udp_destination;
    logic [3:0] ptp_type;
    logic [7:0] domain;
    logic [15:0] sequence_id;
    logic fields_complete;
    logic direction;
    logic [ROW_W-1:0] row;
  } frame_sum_t;

endpackage

// File: rtl/ptp_packet_classifier_rate_limiter.sv
// Top level: PTP frame parser, per-port event budget store and result register.
//
//  channel | signals                                      | item
//  --------+----------------------------------------------+----------------------------
//  in      | in_tvalid in_tready in_tdata in_tuser in_tlast | one frame byte or one tick
//  out     | out_tvalid out_tready out_tdata out_tuser    | one summary per frame end
//  cfg     | cfg_wr_en cfg_addr cfg_wdata                 | one register write
//
// One item per cycle while in_tready is high; a frame's summary and its budget row read
// of the memory are registered when its last byte is taken, then the result register is loaded.
// Budgets are kept as rx/tx pairs, one memory row per port, with a per-row
// written flag; a tick clears all flags at once, so no clearing pass is run.
// in_tready drops only while a finished frame waits behind a stalled output.
module ptp_packet_classifier_rate_limiter
  import ptpcl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // data_byte[7:0], direction[8], port[16:9]
  input  logic                  in_tuser,   // command
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // ptp_type[3:0], domain[11:4],
                                            // sequence_id[27:12], ts_needed[28],
                                            // over_budget[29], frame_direction[30]
  output logic                  out_tuser,  // is_ptp
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BUDGET_W-1:0]   cfg_wdata
);

  // configuration
  logic                ptp_en_r;
  logic [BUDGET_W-1:0] rx_cfg_r, tx_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptp_en_r <= 1'b0;
      rx_cfg_r <= RX_BUDGET_RESET;
      tx_cfg_r <= TX_BUDGET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_PTP_ENABLED: ptp_en_r <= cfg_wdata[0];
        REG_RX_BUDGET:   rx_cfg_r <= cfg_wdata;
        REG_TX_BUDGET:   tx_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input decode
  logic [7:0]       in_byte;
  logic             in_dir;
  logic [ROW_W-1:0] in_row;
  logic             in_acc, byte_acc, tick_acc, last_acc;

  assign in_byte  = in_tdata[7:0];
  assign in_dir   = in_tdata[8];
  assign in_row   = in_tdata[9 +: ROW_W];
  assign in_acc   = in_tvalid && in_tready;
  assign byte_acc = in_acc && (in_tuser == CMD_BYTE);
  assign tick_acc = in_acc && (in_tuser == CMD_TICK);
  assign last_acc = byte_acc && in_tlast;

  // parser state
  logic [7:0]  pos_r, l3_r, np_r;
  logic [15:0] kind_r, udp_r, seq_r;
  logic [3:0]  hw_r, type_r;
  logic [7:0]  dom_r;
  logic        fc_r;

  logic [7:0]  pos_nxt, l3_nxt, np_nxt, dom_nxt, hs, ud4;
  logic [15:0] kind_nxt, udp_nxt, seq_nxt;
  logic [3:0]  hw_nxt, type_nxt;
  logic        fc_nxt, kind_hit, in_l3, is_v4, is_v6;

  always_comb begin
    kind_hit = (pos_r == l3_r - 8'd2) || (pos_r == l3_r - 8'd1);
    kind_nxt = kind_hit ? {kind_r[7:0], in_byte} : kind_r;
    l3_nxt   = l3_r;
    if (kind_hit && pos_r == 8'd13 && l3_r == L3_PLAIN && kind_nxt == KIND_VLAN)
      l3_nxt = L3_TAGGED;

    in_l3 = (pos_r >= l3_r);
    is_v4 = (kind_r == KIND_IPV4);
    is_v6 = (kind_r == KIND_IPV6);
    ud4   = l3_r + {2'b00, hw_r, 2'b00} + 8'd2;
    // header offset with the IHL known so far; at the IHL byte itself it is beyond reach
    if (is_v4)      hs = l3_r + {2'b00, hw_r, 2'b00} + 8'd8;
    else if (is_v6) hs = l3_r + 8'd48;
    else            hs = l3_r;

    hw_nxt   = hw_r;
    np_nxt   = np_r;
    udp_nxt  = udp_r;
    type_nxt = type_r;
    dom_nxt  = dom_r;
    seq_nxt  = seq_r;
    fc_nxt   = fc_r;
    if (in_l3) begin
      if (is_v4) begin
        if (pos_r == l3_r)          hw_nxt = in_byte[3:0];
        if (pos_r == l3_r + 8'd9)   np_nxt = in_byte;
        if (pos_r == ud4)           udp_nxt[15:8] = in_byte;
        if (pos_r == ud4 + 8'd1)    udp_nxt[7:0] = in_byte;
      end else if (is_v6) begin
        if (pos_r == l3_r + 8'd6)   np_nxt = in_byte;
        if (pos_r == l3_r + 8'd42)  udp_nxt[15:8] = in_byte;
        if (pos_r == l3_r + 8'd43)  udp_nxt[7:0] = in_byte;
      end
      if (pos_r == hs)              type_nxt = in_byte[3:0];
      if (pos_r == hs + 8'd4)       dom_nxt = in_byte;
      if (pos_r == hs + 8'd30)      seq_nxt[15:8] = in_byte;
      if (pos_r == hs + 8'd31) begin
        seq_nxt[7:0] = in_byte;
        fc_nxt       = 1'b1;
      end
    end
    pos_nxt = (pos_r == 8'hFF) ? pos_r : pos_r + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last_acc) begin
      pos_r  <= '0;
      kind_r <= '0;
      l3_r   <= L3_PLAIN;
      hw_r   <= '0;
      np_r   <= '0;
      udp_r  <= '0;
      type_r <= '0;
      dom_r  <= '0;
      seq_r  <= '0;
      fc_r   <= 1'b0;
    end else if (byte_acc) begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      l3_r   <= l3_nxt;
      hw_r   <= hw_nxt;
      np_r   <= np_nxt;
      udp_r  <= udp_nxt;
      type_r <= type_nxt;
      dom_r  <= dom_nxt;
      seq_r  <= seq_nxt;
      fc_r   <= fc_nxt;
    end
  end

  // frame summary stage, waits on the budget row read
  frame_sum_t s1_r;
  logic       s1_valid_r;
  logic       out_load, s1_adv;

  assign out_load  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n)        s1_valid_r <= 1'b0;
    else if (last_acc) s1_valid_r <= 1'b1;
    else if (s1_adv)   s1_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (last_acc) begin
      s1_r.kind            <= kind_nxt;
      s1_r.next_protocol   <= np_nxt;
      s1_r.udp_destination <= udp_nxt;
      s1_r.ptp_type        <= type_nxt;
      s1_r.domain          <= dom_nxt;
      s1_r.sequence_id     <= seq_nxt;
      s1_r.fields_complete <= fc_nxt;
      s1_r.direction       <= in_dir;
      s1_r.row             <= in_row;
    end
  end

  // budget memory: row = {tx, rx}
  logic [2*BUDGET_W-1:0] budget_mem [PORTS];
  logic [2*BUDGET_W-1:0] mem_q, fwd_data_r, wr_data, row_data;
  logic                  fwd_r, wr_en;
  logic [PORTS-1:0]      written_r;
  logic [BUDGET_W-1:0]   tick_rx_r, tick_tx_r;

  always_ff @(posedge clk) begin
    if (wr_en) budget_mem[s1_r.row] <= wr_data;
    if (last_acc) mem_q <= budget_mem[in_row];
  end

  // a row written in the same cycle as it is read comes from the write data
  always_ff @(posedge clk) begin
    if (!rst_n) fwd_r <= 1'b0;
    else if (last_acc) fwd_r <= wr_en && (s1_r.row == in_row);
  end

  always_ff @(posedge clk) begin
    if (last_acc) fwd_data_r <= wr_data;
  end

  // tick values start at zero: a row untouched before the first tick is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rx_r <= '0;
      tick_tx_r <= '0;
    end else if (tick_acc) begin
      tick_rx_r <= rx_cfg_r;
      tick_tx_r <= tx_cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (tick_acc) begin
      written_r <= '0;  // tick follows the frame in flight
    end else if (wr_en) begin
      written_r[s1_r.row] <= 1'b1;
    end
  end

  // classification and budget update
  logic                kind_ok, udp_ok, ptp, ts, over;
  logic [BUDGET_W-1:0] eff_rx, eff_tx, cur, cur_nxt;

  always_comb begin
    udp_ok  = (s1_r.next_protocol == PROTO_UDP) &&
              (s1_r.udp_destination == PTP_EVENT_PORT ||
               s1_r.udp_destination == PTP_GENERAL_PORT);
    kind_ok = (s1_r.kind == KIND_PTP) ||
              ((s1_r.kind == KIND_IPV4 || s1_r.kind == KIND_IPV6) && udp_ok);
    ptp     = kind_ok && s1_r.fields_complete && !(s1_r.direction && !ptp_en_r);
    ts      = ptp && (s1_r.ptp_type <= 4'd3);

    row_data = fwd_r ? fwd_data_r : mem_q;
    eff_rx   = written_r[s1_r.row] ? row_data[BUDGET_W-1:0] : tick_rx_r;
    eff_tx   = written_r[s1_r.row] ? row_data[2*BUDGET_W-1:BUDGET_W] : tick_tx_r;
    cur      = s1_r.direction ? eff_tx : eff_rx;
    over     = ts && (cur == '0);
    cur_nxt  = (cur == '0) ? cur : cur - {{(BUDGET_W-1){1'b0}}, 1'b1};
    wr_data  = s1_r.direction ? {cur_nxt, eff_rx} : {eff_tx, cur_nxt};
    wr_en    = s1_adv && ts;
  end

  // result register
  logic                  out_valid_r, out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt = '0;
    if (ptp) begin
      out_data_nxt[OUT_TYPE_LSB +: 4]   = s1_r.ptp_type;
      out_data_nxt[OUT_DOMAIN_LSB +: 8] = s1_r.domain;
      out_data_nxt[OUT_SEQ_LSB +: 16]   = s1_r.sequence_id;
    end
    out_data_nxt[OUT_TS_BIT]   = ts;
    out_data_nxt[OUT_OVER_BIT] = over;
    out_data_nxt[OUT_DIR_BIT]  = s1_r.direction;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (s1_adv)     out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_user_r <= ptp;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/ptpcl_checker.sv
// Port-level checks for the PTP classifier and rate limiter, bound to the top level.
module ptpcl_port_asserts
  import ptpcl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // non-PTP frames carry only the direction
  a_not_ptp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_OVER_BIT:0] == '0)
    else $error("non-PTP result has PTP fields set");

  // over budget only on event messages
  a_over_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_OVER_BIT] |-> out_tdata[OUT_TS_BIT])
    else $error("over_budget without ts_needed");

  // timestamp needed exactly for event types
  a_ts_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[OUT_TS_BIT] == (out_tdata[OUT_TYPE_LSB +: 4] <= 4'd3))
    else $error("ts_needed does not match message type");

endmodule

bind ptp_packet_classifier_rate_limiter ptpcl_port_asserts u_port_asserts (.*);
